// ----- design/ort_pkg.sv -----
package ort_pkg;

   localparam int CHANNELS = 32;
   localparam int CHANNEL_W = 5;
   localparam int DEPTH = (CHANNELS < (1 << CHANNEL_W)) ? CHANNELS : (1 << CHANNEL_W);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_CURRENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_MINUTES = 2'd1;

   localparam logic [15:0] MIN_CURRENT_RESET = 16'd90;
   localparam logic [7:0] UNIT_MINUTES_RESET = 8'd30;

   typedef struct packed {
      logic [7:0] low_current_seconds;
      logic [7:0] minute_count;
      logic [7:0] run_units;
      logic [7:0] trickle_units;
   } counters_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 relay_on;
      logic                 trickle_on;
      logic [15:0]          current;
      logic                 second_tick;
      logic                 minute_tick;
   } request_type;

   typedef struct packed {
      logic [15:0] min_current;
      logic [7:0]  unit_minutes;
   } config_type;

endpackage

// ----- design/ort_counter_ram.sv -----
module ort_counter_ram (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [ort_pkg::ADDR_W-1:0] rd_addr,
   input  logic                      wr_en,
   input  logic [ort_pkg::ADDR_W-1:0] wr_addr,
   input  ort_pkg::counters_type     wr_data,
   output ort_pkg::counters_type     rd_data
);

   ort_pkg::counters_type mem [ort_pkg::DEPTH];
   logic [ort_pkg::DEPTH-1:0] valid_ff;

   ort_pkg::counters_type rd_data_ff;
   logic                  rd_valid_ff;
   logic                  fwd_ff;
   ort_pkg::counters_type fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
            fwd_ff <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   // read in the cycle of a write to the same entry sees the new data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_valid_ff) begin
         rd_data = rd_data_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ----- design/ort_update.sv -----
module ort_update (
   input  ort_pkg::request_type  request,
   input  ort_pkg::config_type   cfg,
   input  ort_pkg::counters_type old_counters,
   output ort_pkg::counters_type new_counters
);

   logic [7:0] minute_next;

   always_comb begin
      new_counters = old_counters;
      minute_next = 8'(old_counters.minute_count + 8'd1);

      if (request.relay_on && request.second_tick) begin
         if (request.current < cfg.min_current) begin
            new_counters.low_current_seconds = 8'(old_counters.low_current_seconds + 8'd1);
         end else begin
            new_counters.low_current_seconds = 8'd0;
         end
      end

      if (request.relay_on && request.minute_tick) begin
         // compare on the wrapped count; a unit length of zero always completes
         if (minute_next >= cfg.unit_minutes) begin
            new_counters.minute_count = 8'd0;
            new_counters.run_units = 8'(old_counters.run_units + 8'd1);
            if (request.trickle_on) begin
               new_counters.trickle_units = 8'(old_counters.trickle_units + 8'd1);
            end
         end else begin
            new_counters.minute_count = minute_next;
         end
      end
   end

endmodule

// ----- design/outlet_runtime_and_idle_timers.sv -----
// Per-outlet run-time and idle timers.
// A request on the req_ channel names an outlet and carries its relay and
// trickle state, the measured current and the second/minute tick flags.
// Every request yields one response on the rsp_ channel with the outlet's
// counters after the update; responses come out in request order.
// A taken request is registered in the update stage, its response in the
// output register. Throughput: one request per cycle while responses are
// taken; counters are read when a request is taken and written back as it
// leaves the update stage; a request to an outlet just written is forwarded.
// When rsp_ready is low the response holds in the output register, one
// more request may wait in the update stage, and req_ready then drops.
// csr_ writes set the low-current threshold (index 0) and the minutes per
// run unit (index 1); csr_ready is always high. The user must put writes
// in while idle; the block does not enforce it. Reset restores defaults
// and clears per-outlet valid bits at once: counters read zero, no clear pass.
module outlet_runtime_and_idle_timers (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ort_pkg::CHANNEL_W-1:0]     req_channel,
   input  logic                              req_relay_on,
   input  logic                              req_trickle_on,
   input  logic [15:0]                       req_current,
   input  logic                              req_second_tick,
   input  logic                              req_minute_tick,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ort_pkg::CHANNEL_W-1:0]     rsp_channel_out,
   output logic [7:0]                        rsp_low_current_seconds,
   output logic [7:0]                        rsp_minute_count,
   output logic [7:0]                        rsp_run_units,
   output logic [7:0]                        rsp_trickle_units,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ort_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ort_pkg::CSR_DATA_W-1:0]    csr_data
);

   ort_pkg::config_type   cfg_ff;
   ort_pkg::request_type  req_in;
   ort_pkg::request_type  s1_req_ff;
   logic                  s1_valid_ff;
   logic                  s1_in_range;
   logic                  s1_advance;
   logic                  req_accept;
   logic                  req_in_range;
   ort_pkg::counters_type old_counters;
   ort_pkg::counters_type new_counters;
   logic                  rsp_valid_ff;
   logic [ort_pkg::CHANNEL_W-1:0] rsp_channel_ff;
   ort_pkg::counters_type rsp_counters_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_current <= ort_pkg::MIN_CURRENT_RESET;
         cfg_ff.unit_minutes <= ort_pkg::UNIT_MINUTES_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ort_pkg::CSR_MIN_CURRENT: cfg_ff.min_current <= csr_data[15:0];
            ort_pkg::CSR_UNIT_MINUTES: cfg_ff.unit_minutes <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign req_in = '{channel: req_channel, relay_on: req_relay_on,
                     trickle_on: req_trickle_on, current: req_current,
                     second_tick: req_second_tick, minute_tick: req_minute_tick};

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;
   assign req_in_range = 9'(req_channel) < 9'(ort_pkg::CHANNELS);
   assign s1_in_range = 9'(s1_req_ff.channel) < 9'(ort_pkg::CHANNELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_in;
      end
   end

   ort_counter_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept && req_in_range),
      .rd_addr (req_channel[ort_pkg::ADDR_W-1:0]),
      .wr_en   (s1_advance && s1_in_range),
      .wr_addr (s1_req_ff.channel[ort_pkg::ADDR_W-1:0]),
      .wr_data (new_counters),
      .rd_data (old_counters)
   );

   ort_update u_update (
      .request      (s1_req_ff),
      .cfg          (cfg_ff),
      .old_counters (old_counters),
      .new_counters (new_counters)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // outlets beyond the store report zero counters
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_channel_ff <= s1_req_ff.channel;
         rsp_counters_ff <= s1_in_range ? new_counters : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_low_current_seconds = rsp_counters_ff.low_current_seconds;
   assign rsp_minute_count = rsp_counters_ff.minute_count;
   assign rsp_run_units = rsp_counters_ff.run_units;
   assign rsp_trickle_units = rsp_counters_ff.trickle_units;

   a_stage_to_output: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("update stage advanced without loading a response");

   a_ready_only_blocked_by_stage: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request refused without a stalled response");

   a_relay_off_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_req_ff.relay_on) |-> (new_counters == old_counters))
      else $error("counters changed with relay off");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !s1_in_range) |=> (rsp_counters_ff == '0))
      else $error("out-of-range outlet reported nonzero counters");

endmodule
